// ----- hdl/u8u16_pkg.sv -----
`default_nettype none

package u8u16_pkg;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_TWO_LAST,
      PH_THREE_FIRST,
      PH_THREE_LAST,
      PH_STOP
   } phase_type;

   localparam logic [1:0] ST_UNIT = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [2:0] LEAD2_PREFIX = 3'h6;
   localparam logic [3:0] LEAD3_PREFIX = 4'he;

   localparam logic [15:0] CAPACITY_RESET = 16'hffff;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [1:0]  status;
      logic [15:0] units_written;
      logic        terminator_fits;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] partial_unit;
      logic        error_seen;
   } string_state_type;

endpackage

`default_nettype wire

// ----- hdl/u8u16_decode.sv -----
`default_nettype none

module u8u16_decode #(
   parameter int COUNT_BITS = 16
) (
   input  u8u16_pkg::string_state_type state,
   input  logic [COUNT_BITS-1:0]       unit_count,
   input  logic [15:0]                 capacity,
   input  logic [7:0]                  data_byte,
   input  logic                        last_byte,
   output u8u16_pkg::string_state_type state_next,
   output logic [COUNT_BITS-1:0]       unit_count_next,
   output logic                        unit_valid,
   output u8u16_pkg::result_type       unit_result,
   output u8u16_pkg::result_type       end_result
);
   import u8u16_pkg::*;

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   string_state_type       work;
   logic [15:0]            unit_value;
   logic [COUNT_BITS-1:0]  count_upd;
   logic [CMP_W-1:0]       count_ext;
   logic [CMP_W-1:0]       count_upd_ext;
   logic [CMP_W-1:0]       cap_ext;

   assign count_ext = CMP_W'(unit_count);
   assign cap_ext   = CMP_W'(capacity);

   always_comb begin
      work       = state;
      unit_valid = 1'b0;
      unit_value = 16'd0;
      unique case (state.phase)
         PH_LEAD: begin
            if (count_ext >= cap_ext) begin
               work.phase = PH_STOP;
            end else if (!data_byte[7]) begin
               unit_valid = 1'b1;
               unit_value = {8'd0, data_byte};
            end else if (data_byte[7:5] == LEAD2_PREFIX) begin
               work.partial_unit = {5'd0, data_byte[4:0], 6'd0};
               work.phase        = PH_TWO_LAST;
            end else if (data_byte[7:4] == LEAD3_PREFIX) begin
               work.partial_unit = {data_byte[3:0], 12'd0};
               work.phase        = PH_THREE_FIRST;
            end else begin
               work.error_seen = 1'b1;
               work.phase      = PH_STOP;
            end
         end
         PH_TWO_LAST, PH_THREE_LAST: begin
            unit_valid        = 1'b1;
            unit_value        = state.partial_unit + {10'd0, data_byte[5:0]};
            work.partial_unit = 16'd0;
            work.phase        = PH_LEAD;
         end
         PH_THREE_FIRST: begin
            work.partial_unit = state.partial_unit + {4'd0, data_byte[5:0], 6'd0};
            work.phase        = last_byte ? PH_STOP : PH_THREE_LAST;
         end
         default: begin
         end
      endcase
   end

   assign count_upd     = (unit_valid && unit_count != COUNT_MAX) ? unit_count + 1'b1
                                                                   : unit_count;
   assign count_upd_ext = CMP_W'(count_upd);

   always_comb begin
      unit_result.code_unit       = unit_value;
      unit_result.status          = ST_UNIT;
      unit_result.units_written   = 16'd0;
      unit_result.terminator_fits = 1'b0;

      end_result.code_unit        = 16'd0;
      end_result.status           = work.error_seen ? ST_BAD : ST_OK;
      end_result.units_written    = count_upd_ext[15:0];
      end_result.terminator_fits  = count_upd_ext < cap_ext;
   end

   always_comb begin
      if (last_byte) begin
         state_next.phase        = PH_LEAD;
         state_next.partial_unit = 16'd0;
         state_next.error_seen   = 1'b0;
         unit_count_next         = '0;
      end else begin
         state_next      = work;
         unit_count_next = count_upd;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/u8u16_queue.sv -----
`default_nettype none

module u8u16_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_first,
   input  logic                  push_second,
   input  u8u16_pkg::result_type first_data,
   input  u8u16_pkg::result_type second_data,
   output logic                  room_for_two,
   output logic                  out_valid,
   input  logic                  out_ready,
   output u8u16_pkg::result_type out_data
);
   import u8u16_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   level_ff, level_in;
   logic [PTR_W-1:0]   wr_next_ptr;
   logic               pop;
   logic [CNT_W-1:0]   push_count;

   assign out_valid    = level_ff != '0;
   assign out_data     = slot_ff[rd_ptr_ff];
   assign room_for_two = level_ff <= CNT_W'(DEPTH - 2);
   assign pop          = out_valid && out_ready;
   assign wr_next_ptr  = wr_ptr_ff + 1'b1;
   assign push_count   = CNT_W'(push_first) + CNT_W'(push_second);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign level_in  = level_ff + push_count - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         slot_ff[wr_ptr_ff] <= first_data;
      end
      if (push_second) begin
         slot_ff[wr_next_ptr] <= second_data;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= CNT_W'(DEPTH))
      else $error("result queue level beyond its depth");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push_second |-> push_first)
      else $error("second result pushed without a first");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_first && !room_for_two) |-> (push_count <= CNT_W'(1)) && (level_ff < CNT_W'(DEPTH)))
      else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- hdl/utf8_to_utf16_decoder_top.sv -----
`default_nettype none

// UTF-8 to UTF-16 decoder for the Basic Multilingual Plane. Bytes of one string enter on the
// req_ stream, with tlast on the final byte; each complete 1-, 2- or 3-byte sequence gives one
// code unit (tuser 0) on the rsp_ stream, and the final byte adds an end item (tuser 1 for
// success, 2 for an invalid lead byte) carrying the unit count and whether a terminator fits.
// Decoding stops with success when the unit count reaches the capacity register before a lead
// byte. A byte is taken in every cycle while the four-entry result queue has room for two
// items, so one byte per cycle is sustained; the end item adds one extra output item, so
// the rsp_ side sets the limit. Each byte's results are registered in the result queue.
module utf8_to_utf16_decoder_top #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // code_unit[15:0], units_written[31:16], terminator_fits[32]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import u8u16_pkg::*;

   string_state_type       state_ff, state_in;
   logic [COUNT_BITS-1:0]  unit_count_ff, unit_count_in;
   logic [15:0]            capacity_ff;
   logic                   accept;
   logic                   unit_valid;
   result_type             unit_result;
   result_type             end_result;
   logic                   room_for_two;
   logic                   push_first;
   logic                   push_second;
   result_type             first_data;
   result_type             out_data;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {16'd0, capacity_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write && csr_paddr[2] == 1'b0) begin
         capacity_ff <= csr_pwdata[15:0];
      end
   end

   assign req_tready = room_for_two;
   assign accept     = req_tvalid && req_tready;

   u8u16_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .state           (state_ff),
      .unit_count      (unit_count_ff),
      .capacity        (capacity_ff),
      .data_byte       (req_tdata),
      .last_byte       (req_tlast),
      .state_next      (state_in),
      .unit_count_next (unit_count_in),
      .unit_valid      (unit_valid),
      .unit_result     (unit_result),
      .end_result      (end_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_LEAD;
         state_ff.partial_unit <= 16'd0;
         state_ff.error_seen   <= 1'b0;
         unit_count_ff         <= '0;
      end else if (accept) begin
         state_ff      <= state_in;
         unit_count_ff <= unit_count_in;
      end
   end

   assign push_first  = accept && (unit_valid || req_tlast);
   assign push_second = accept && unit_valid && req_tlast;
   assign first_data  = unit_valid ? unit_result : end_result;

   u8u16_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_first   (push_first),
      .push_second  (push_second),
      .first_data   (first_data),
      .second_data  (end_result),
      .room_for_two (room_for_two),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (out_data)
   );

   assign rsp_tdata = {7'd0, out_data.terminator_fits, out_data.units_written,
                       out_data.code_unit};
   assign rsp_tuser = out_data.status;

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (unit_count_ff == '0) && (state_ff.phase == PH_LEAD)
                                && !state_ff.error_seen)
      else $error("string state not cleared after the end item");

   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == PH_STOP) |-> !unit_valid)
      else $error("code unit produced while stopped");

   a_three_byte_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast && state_ff.phase == PH_THREE_FIRST)
      |=> state_ff.phase == PH_THREE_LAST)
      else $error("three-byte sequence lost its second continuation step");

endmodule

`default_nettype wire

// ----- tb/utf8_to_utf16_decoder_top_tb.sv -----
`default_nettype none

module utf8_to_utf16_decoder_top_tb;
   import u8u16_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          COUNT_BITS    = 16;
   localparam logic [2:0]  CAPACITY_ADDR = 3'd0;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          DRAIN_CYCLES  = 4;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          ITEMS_PER_MODE = 460;
   localparam int          LONG_STRING   = 200;
   localparam logic [15:0] LONG_CAPACITY = 16'd150;

   typedef struct packed {
      logic        set_cap;
      logic [15:0] cap;
      logic [7:0]  data;
      logic        last;
      logic        pinned;
      logic [1:0]  status;
      logic [15:0] units;
      logic        fits;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 25;

   // Rows that end a string with a plain, easily read outcome carry their end item here.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, ST_OK,  16'd1, 1'b1},
      '{1'b0, 16'h0000, 8'h7f, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'hc2, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'ha9, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'he2, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'h82, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'hac, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'hff, 1'b1, 1'b1, ST_BAD, 16'd3, 1'b1},
      '{1'b0, 16'h0000, 8'hc3, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'hef, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'hff, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'hff, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'he0, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'hbf, 1'b1, 1'b1, ST_OK,  16'd2, 1'b1},
      '{1'b0, 16'h0000, 8'hdf, 1'b1, 1'b1, ST_OK,  16'd0, 1'b1},
      '{1'b0, 16'h0000, 8'hf0, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'h41, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'h80, 1'b1, 1'b1, ST_BAD, 16'd0, 1'b1},
      '{1'b1, 16'h0000, 8'h41, 1'b1, 1'b1, ST_OK,  16'd0, 1'b0},
      '{1'b1, 16'h0001, 8'hc2, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'ha9, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'h41, 1'b0, 1'b0, ST_UNIT, 16'd0, 1'b0},
      '{1'b0, 16'h0000, 8'h42, 1'b1, 1'b1, ST_OK,  16'd1, 1'b0},
      '{1'b1, 16'hffff, 8'h80, 1'b1, 1'b1, ST_BAD, 16'd0, 1'b1}
   };

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // data_byte[7:0]
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // code_unit[15:0], units_written[31:16], terminator_fits[32]
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;             // status[1:0]
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   utf8_to_utf16_decoder_top #(
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Decoder state as the block should hold it.
   phase_type             dec_phase    = PH_LEAD;
   logic [15:0]           dec_partial  = '0;
   logic [COUNT_BITS-1:0] dec_count    = '0;
   logic                  dec_error    = 1'b0;
   logic [15:0]           dec_capacity = CAPACITY_RESET;

   result_type awaited_results [$];
   result_type got_result;
   result_type want_result;

   int  send_idle       = 0;
   int  recv_idle       = 0;
   bit  hold_req        = 1'b0;
   int  errors          = 0;
   int  results_checked = 0;
   int  bytes_sent      = 0;
   int  strings_sent    = 0;
   int  capacity_writes = 0;
   int  cycle_count     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
                  awaited_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void decode_byte(input logic [7:0] b, input logic l,
                                       output result_type res [2], output int n);
      logic        have_unit;
      logic [15:0] unit_val;
      have_unit = 1'b0;
      unit_val  = '0;
      n         = 0;
      res[0]    = '0;
      res[1]    = '0;
      case (dec_phase)
         PH_LEAD: begin
            if (dec_count >= dec_capacity) begin
               dec_phase = PH_STOP;
            end else if (b[7] == 1'b0) begin
               have_unit = 1'b1;
               unit_val  = {8'h00, b};
            end else if (b[7:5] == LEAD2_PREFIX) begin
               dec_partial = {5'd0, b[4:0], 6'd0};
               dec_phase   = PH_TWO_LAST;
            end else if (b[7:4] == LEAD3_PREFIX) begin
               dec_partial = {b[3:0], 12'd0};
               dec_phase   = PH_THREE_FIRST;
            end else begin
               dec_error = 1'b1;
               dec_phase = PH_STOP;
            end
         end
         PH_TWO_LAST, PH_THREE_LAST: begin
            have_unit   = 1'b1;
            unit_val    = dec_partial + {10'd0, b[5:0]};
            dec_partial = '0;
            dec_phase   = PH_LEAD;
         end
         PH_THREE_FIRST: begin
            dec_partial = dec_partial + {4'd0, b[5:0], 6'd0};
            dec_phase   = l ? PH_STOP : PH_THREE_LAST;
         end
         default: begin
         end
      endcase
      if (have_unit) begin
         res[n] = '{unit_val, ST_UNIT, 16'd0, 1'b0};
         n++;
         if (dec_count != '1) dec_count++;
      end
      if (l) begin
         res[n] = '{16'd0, dec_error ? ST_BAD : ST_OK, 16'(dec_count),
                    (dec_count < dec_capacity)};
         n++;
         dec_phase   = PH_LEAD;
         dec_partial = '0;
         dec_count   = '0;
         dec_error   = 1'b0;
      end
   endfunction

   function automatic logic [7:0] tail_byte();
      if ($urandom_range(9) == 0) return 8'($urandom);
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic l, input logic pin_end,
                            input result_type pinned_end);
      result_type res [2];
      int         n;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, l, res, n);
      if (pin_end) res[n-1] = pinned_end;
      for (int i = 0; i < n; i++) awaited_results.push_back(res[i]);
      bytes_sent++;
      if (l) strings_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      dec_capacity = value;
      capacity_writes++;
   endtask

   task automatic send_random_string();
      logic [7:0] text [$];
      int         pick;
      repeat ($urandom_range(1, 12)) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            text.push_back(8'($urandom_range(0, 127)));
         end else if (pick < 65) begin
            text.push_back(8'hc0 | 8'($urandom_range(0, 31)));
            text.push_back(tail_byte());
         end else if (pick < 88) begin
            text.push_back(8'he0 | 8'($urandom_range(0, 15)));
            text.push_back(tail_byte());
            text.push_back(tail_byte());
         end else if (pick < 95) begin
            text.push_back($urandom_range(1) ? (8'h80 | 8'($urandom_range(0, 63)))
                                             : (8'hf0 | 8'($urandom_range(0, 15))));
         end else begin
            text.push_back(8'($urandom));
         end
      end
      // Now and then the string is cut off in the middle of a sequence.
      pick = $urandom_range(9);
      if (pick == 0) begin
         text.push_back(8'hc0 | 8'($urandom_range(0, 31)));
      end else if (pick == 1) begin
         text.push_back(8'he0 | 8'($urandom_range(0, 15)));
         if ($urandom_range(1)) text.push_back(tail_byte());
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1, 1'b0, '0);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result.code_unit       = rsp_tdata[15:0];
         got_result.status          = rsp_tuser;
         got_result.units_written   = rsp_tdata[31:16];
         got_result.terminator_fits = rsp_tdata[32];
         results_checked++;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected item: unit %h status %0d units %0d fits %b",
                        got_result.code_unit, got_result.status, got_result.units_written,
                        got_result.terminator_fits);
         end else begin
            want_result = awaited_results.pop_front();
            if (got_result !== want_result) begin
               errors++;
               if (errors <= 10) begin
                  $display("Mismatch: expected unit %h status %0d units %0d fits %b",
                           want_result.code_unit, want_result.status,
                           want_result.units_written, want_result.terminator_fits);
                  $display("          got unit %h status %0d units %0d fits %b",
                           got_result.code_unit, got_result.status,
                           got_result.units_written, got_result.terminator_fits);
               end
            end
         end
      end
   end

   initial begin
      int mode;
      int target;
      int pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 24;
      recv_idle = 74;
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].set_cap) write_capacity(DIRECTED_ROWS[i].cap);
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].pinned,
                   '{16'd0, DIRECTED_ROWS[i].status, DIRECTED_ROWS[i].units,
                     DIRECTED_ROWS[i].fits});
      end

      for (mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 24 : (mode == 1) ? 74 : 0;
         recv_idle = (mode == 0) ? 74 : (mode == 1) ? 24 : 0;
         // The receiver stalls for a long stretch while bytes keep coming.
         if (mode == 0) hold_req = 1'b1;
         target = bytes_sent + ITEMS_PER_MODE;
         while (bytes_sent < target) begin
            if ($urandom_range(7) == 0) begin
               pick = $urandom_range(9);
               if (pick < 3) write_capacity(16'($urandom_range(0, 3)));
               else if (pick < 6) write_capacity(16'($urandom_range(4, 30)));
               else if (pick < 8) write_capacity(16'($urandom));
               else write_capacity(CAPACITY_RESET);
            end
            send_random_string();
         end
      end

      // One long string that runs into the capacity limit part way through.
      write_capacity(LONG_CAPACITY);
      for (int i = 0; i < LONG_STRING; i++)
         send_byte(8'($urandom_range(0, 127)), i == LONG_STRING - 1, 1'b0, '0);
      drain();

      $display("Sent %0d bytes in %0d strings and checked %0d result items.",
               bytes_sent, strings_sent, results_checked);
      $display("Capacity was written %0d times, from zero up to 65535, under stalls on both sides.",
               capacity_writes);
      if (errors == 0 && awaited_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches.", errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
